FILE: rtl/core/quaternion_axpy_scale_macros.svh
// assertion macros for the quaternion scale / axpy block
`ifndef QUATERNION_AXPY_SCALE_MACROS_SVH
`define QUATERNION_AXPY_SCALE_MACROS_SVH

// checked only while reset is low
`define QAXS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define QAXS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/qaxs_pkg.sv
package qaxs_pkg;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned LATENCY   = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_W  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_I  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_J  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_K  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MUL_SIDE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE  = 3'd5;

   localparam logic signed [31:0] ALPHA_W_RESET = 32'sh0001_0000;
   localparam logic               OP_MODE_RESET = 1'b1;

   // hamilton product: component c, term n is a[n] * b[B_SEL[c][n]]
   localparam logic [1:0] B_SEL [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };

   // bit n set: term n is subtracted
   localparam logic [3:0] NEG_MASK [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

   typedef struct packed {
      logic signed [31:0] x_w;
      logic signed [31:0] x_i;
      logic signed [31:0] x_j;
      logic signed [31:0] x_k;
      logic signed [31:0] y_w;
      logic signed [31:0] y_i;
      logic signed [31:0] y_j;
      logic signed [31:0] y_k;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_w;
      logic signed [31:0] r_i;
      logic signed [31:0] r_j;
      logic signed [31:0] r_k;
      logic               last_out;
   } rsp_type;

endpackage

FILE: rtl/core/qaxs_lane.sv
module qaxs_lane import qaxs_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] a_op [4],
   input  logic signed [31:0] b_op [4],
   input  logic [3:0]         neg_mask,
   input  logic signed [31:0] y_op,
   input  logic               add_y,
   output logic signed [31:0] result
);

   logic signed [63:0] prod_ff [4];
   logic signed [63:0] prod_in [4];
   logic signed [64:0] term    [4];
   logic signed [64:0] pair_ff [2];
   logic signed [64:0] pair_in [2];
   logic signed [65:0] total;
   logic signed [49:0] shift_ff;
   logic signed [49:0] shift_in;
   logic signed [31:0] y_ff [3];
   logic signed [50:0] sum_y;
   logic signed [31:0] res_ff;
   logic signed [31:0] res_in;

   // stage 1: four 32x32 products
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         prod_in[n] = 64'(a_op[n]) * 64'(b_op[n]);
      end
   end

   // stage 2: signed terms, pairwise sums
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         if (neg_mask[n]) begin
            term[n] = -{prod_ff[n][63], prod_ff[n]};
         end else begin
            term[n] = {prod_ff[n][63], prod_ff[n]};
         end
      end
      pair_in[0] = term[0] + term[1];
      pair_in[1] = term[2] + term[3];
   end

   // stage 3: full sum, floor shift by 16
   assign total    = {pair_ff[0][64], pair_ff[0]} + {pair_ff[1][64], pair_ff[1]};
   assign shift_in = total[65:16];

   // stage 4: add y, clamp to 32 bits
   always_comb begin
      if (add_y) begin
         sum_y = {shift_ff[49], shift_ff} + {{19{y_ff[2][31]}}, y_ff[2]};
      end else begin
         sum_y = {shift_ff[49], shift_ff};
      end
      if (sum_y[50:31] == {20{sum_y[31]}}) begin
         res_in = sum_y[31:0];
      end else if (sum_y[50]) begin
         res_in = {1'b1, 31'd0};
      end else begin
         res_in = {1'b0, {31{1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      pair_ff  <= pair_in;
      shift_ff <= shift_in;
      res_ff   <= res_in;
      y_ff[0]  <= y_op;
      y_ff[1]  <= y_ff[0];
      y_ff[2]  <= y_ff[1];
   end

   assign result = res_ff;

endmodule

FILE: rtl/core/quaternion_axpy_scale.sv
// quaternion scale / axpy: r = alpha*x or x*alpha, plus y in axpy mode
// req channel: an item (x, y, last flag) is taken at each clock edge where
//   start is high and busy is low; busy stays low, so one item per cycle
// rsp channel: each result is shown for exactly one cycle with rsp_valid
//   high, in the order the items came in
// datapath: an item taken at an edge passes through four registered stages
//   (multiply, pair add, sum and shift, add y and clamp) on its way to the
//   rsp ports
// throughput: one item per cycle, sixteen multipliers in four lanes
// csr channel: csr_index selects alpha_w, alpha_i, alpha_j, alpha_k,
//   mul_side, op_mode; csr_ready is always high, unknown indexes ignored;
//   write only while no item is in flight
// reset (synchronous, active high) drops every item in flight and loads
//   alpha = 1, mul_side 0, op_mode 1 (axpy)
// the receiver cannot stall: nothing holds the pipe, results are never
//   held back
module quaternion_axpy_scale import qaxs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   logic signed [31:0] alpha_ff [4];
   logic signed [31:0] alpha_in [4];
   logic               mul_side_ff;
   logic               mul_side_in;
   logic               op_mode_ff;
   logic               op_mode_in;

   logic               accept;
   logic [3:0]         valid_ff;
   logic [3:0]         valid_in;
   logic [3:0]         last_ff;
   logic [2:0]         mode_pipe_ff;

   logic signed [31:0] x_op  [4];
   logic signed [31:0] y_op  [4];
   logic signed [31:0] op_a  [4];
   logic signed [31:0] op_b  [4];
   logic signed [31:0] lane_b [4][4];
   logic signed [31:0] lane_r [4];

   // pipe never stalls, so an item is taken whenever offered
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // configuration registers
   always_comb begin
      alpha_in    = alpha_ff;
      mul_side_in = mul_side_ff;
      op_mode_in  = op_mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ALPHA_W:  alpha_in[0] = csr_wdata;
            CSR_ALPHA_I:  alpha_in[1] = csr_wdata;
            CSR_ALPHA_J:  alpha_in[2] = csr_wdata;
            CSR_ALPHA_K:  alpha_in[3] = csr_wdata;
            CSR_MUL_SIDE: mul_side_in = csr_wdata[0];
            CSR_OP_MODE:  op_mode_in  = csr_wdata[0];
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff[0] <= ALPHA_W_RESET;
         alpha_ff[1] <= '0;
         alpha_ff[2] <= '0;
         alpha_ff[3] <= '0;
         mul_side_ff <= 1'b0;
         op_mode_ff  <= OP_MODE_RESET;
      end else begin
         alpha_ff    <= alpha_in;
         mul_side_ff <= mul_side_in;
         op_mode_ff  <= op_mode_in;
      end
   end

   // operand selection: left and right factor of the hamilton product
   assign x_op[0] = req_data.x_w;
   assign x_op[1] = req_data.x_i;
   assign x_op[2] = req_data.x_j;
   assign x_op[3] = req_data.x_k;
   assign y_op[0] = req_data.y_w;
   assign y_op[1] = req_data.y_i;
   assign y_op[2] = req_data.y_j;
   assign y_op[3] = req_data.y_k;

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         op_a[n] = mul_side_ff ? x_op[n] : alpha_ff[n];
         op_b[n] = mul_side_ff ? alpha_ff[n] : x_op[n];
      end
      // each lane sees the right factor permuted for its component
      for (int c = 0; c < 4; c++) begin
         for (int n = 0; n < 4; n++) begin
            lane_b[c][n] = op_b[B_SEL[c][n]];
         end
      end
   end

   // one lane per result component
   for (genvar c = 0; c < 4; c++) begin : g_lane
      qaxs_lane u_lane (
         .clock    (clock),
         .a_op     (op_a),
         .b_op     (lane_b[c]),
         .neg_mask (NEG_MASK[c]),
         .y_op     (y_op[c]),
         .add_y    (mode_pipe_ff[2]),
         .result   (lane_r[c])
      );
   end

   // valid bits travel alongside the lanes; last flag and mode ride along
   assign valid_in = {valid_ff[2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= {last_ff[2:0], req_data.last_in};
      mode_pipe_ff <= {mode_pipe_ff[1:0], op_mode_ff};
   end

   assign rsp_valid         = valid_ff[LATENCY-1];
   assign rsp_data.r_w      = lane_r[0];
   assign rsp_data.r_i      = lane_r[1];
   assign rsp_data.r_j      = lane_r[2];
   assign rsp_data.r_k      = lane_r[3];
   assign rsp_data.last_out = last_ff[LATENCY-1];

endmodule

FILE: rtl/core/qaxs_check.sv
`include "quaternion_axpy_scale_macros.svh"

module qaxs_check import qaxs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic taken;
   logic last_req;
   logic last_rsp;

   assign taken    = start && !busy;
   assign last_req = req_data.last_in;
   assign last_rsp = rsp_data.last_out;

   // every item taken comes out with rsp_valid
   `QAXS_ASSERT(a_item_out, taken |-> ##4 rsp_valid, "item lost in pipe")

   // no result without an item taken before it
   `QAXS_ASSERT(a_no_extra, rsp_valid |-> $past(taken, 4), "result without item")

   // last flag keeps its item
   `QAXS_ASSERT(a_last_kept, taken |-> ##4 (last_rsp == $past(last_req, 4)), "last flag lost")

   // reset empties the pipe
   `QAXS_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_valid, "result right after reset")

endmodule

bind quaternion_axpy_scale qaxs_check u_qaxs_check (.*);

FILE: test/tb.sv
module tb;
   import qaxs_pkg::*;

   // q16.16 extremes and handy constants
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;
   localparam logic [31:0] Q_TWO = 32'h0002_0000;

   // register indexes that map to nothing, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   // clamp bounds at the width of the exact product sums
   localparam logic signed [67:0] SUM_MAX = 68'sd2147483647;
   localparam logic signed [67:0] SUM_MIN = -68'sd2147483648;

   localparam int WATCHDOG_LIMIT = 500;
   localparam int PHASE_ITEMS    = 75;
   localparam int PHASES         = 12;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   // shadow copy of the block's registers, starts at the reset values
   logic signed [31:0] scale_factor [4] = '{ALPHA_W_RESET, 32'sd0, 32'sd0, 32'sd0};
   logic               right_multiply   = 1'b0;
   logic               add_y            = OP_MODE_RESET;

   rsp_type predicted_results [$];
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;
   bit      idling_on      = 1'b1;

   quaternion_axpy_scale uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // expected result of one item: hamilton product with the scale factor on
   // the chosen side, exact sums floored by 2^16, y added, then one clamp
   function automatic rsp_type hamilton_axpy(input req_type item);
      logic signed [67:0] xq  [4];
      logic signed [67:0] yq  [4];
      logic signed [67:0] lq  [4];
      logic signed [67:0] rq  [4];
      logic signed [67:0] acc [4];
      logic [31:0]        comp [4];
      rsp_type            res;
      xq[0] = $signed(item.x_w);
      xq[1] = $signed(item.x_i);
      xq[2] = $signed(item.x_j);
      xq[3] = $signed(item.x_k);
      yq[0] = $signed(item.y_w);
      yq[1] = $signed(item.y_i);
      yq[2] = $signed(item.y_j);
      yq[3] = $signed(item.y_k);
      for (int c = 0; c < 4; c++) begin
         if (right_multiply) begin
            lq[c] = xq[c];
            rq[c] = scale_factor[c];
         end else begin
            lq[c] = scale_factor[c];
            rq[c] = xq[c];
         end
      end
      acc[0] = lq[0] * rq[0] - lq[1] * rq[1] - lq[2] * rq[2] - lq[3] * rq[3];
      acc[1] = lq[0] * rq[1] + lq[1] * rq[0] + lq[2] * rq[3] - lq[3] * rq[2];
      acc[2] = lq[0] * rq[2] - lq[1] * rq[3] + lq[2] * rq[0] + lq[3] * rq[1];
      acc[3] = lq[0] * rq[3] + lq[1] * rq[2] - lq[2] * rq[1] + lq[3] * rq[0];
      for (int c = 0; c < 4; c++) begin
         // arithmetic shift floors toward minus infinity
         acc[c] = acc[c] >>> 16;
         // y goes in before the clamp
         if (add_y) acc[c] = acc[c] + yq[c];
         if (acc[c] > SUM_MAX) acc[c] = SUM_MAX;
         if (acc[c] < SUM_MIN) acc[c] = SUM_MIN;
         comp[c] = acc[c][31:0];
      end
      res.r_w      = comp[0];
      res.r_i      = comp[1];
      res.r_j      = comp[2];
      res.r_k      = comp[3];
      res.last_out = item.last_in;
      return res;
   endfunction

   function automatic req_type make_item(input logic [31:0] xw, xi, xj, xk,
                                         input logic [31:0] yw, yi, yj, yk,
                                         input logic last);
      req_type item;
      item.x_w     = xw;
      item.x_i     = xi;
      item.x_j     = xj;
      item.x_k     = xk;
      item.y_w     = yw;
      item.y_i     = yi;
      item.y_j     = yj;
      item.y_k     = yk;
      item.last_in = last;
      return item;
   endfunction

   // mostly values of random magnitude so that not every sum saturates,
   // plus full-range words and the corner values
   function automatic logic [31:0] rand_component();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: ;
         1: begin
            case ($urandom_range(0, 3))
               0: v = Q_MAX;
               1: v = Q_MIN;
               2: v = 32'h0;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         default: v = $signed(v) >>> $urandom_range(0, 30);
      endcase
      return v;
   endfunction

   function automatic req_type random_item();
      return make_item(rand_component(), rand_component(), rand_component(),
                       rand_component(), rand_component(), rand_component(),
                       rand_component(), rand_component(),
                       $urandom_range(0, 7) == 0);
   endfunction

   // sender: optional idle gap, then hold start until the block takes the
   // item; start stays high so the next call can stream back to back
   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      // each cycle idles with about 28 percent odds
      while (idling_on && $urandom_range(0, 99) < 28) gap++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      predicted_results.push_back(hamilton_axpy(item));
   endtask

   // stop sending and let the pipe empty
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      // shadow update: only the low bit of the one-bit registers counts
      case (idx)
         CSR_ALPHA_W:  scale_factor[0] = val;
         CSR_ALPHA_I:  scale_factor[1] = val;
         CSR_ALPHA_J:  scale_factor[2] = val;
         CSR_ALPHA_K:  scale_factor[3] = val;
         CSR_MUL_SIDE: right_multiply  = val[0];
         CSR_OP_MODE:  add_y           = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] aw, ai, aj, ak,
                             input logic side, input logic mode);
      wait_idle();
      write_reg(CSR_ALPHA_W, aw);
      write_reg(CSR_ALPHA_I, ai);
      write_reg(CSR_ALPHA_J, aj);
      write_reg(CSR_ALPHA_K, ak);
      write_reg(CSR_MUL_SIDE, {31'b0, side});
      write_reg(CSR_OP_MODE, {31'b0, mode});
   endtask

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want, got);
      if (got !== want)
         log_mismatch($sformatf("%s expected %h got %h", name, want, got));
   endtask

   // checker: every strobed result against the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (predicted_results.size() == 0) begin
            log_mismatch($sformatf("result %h with no item outstanding", rsp_data));
         end else begin
            want = predicted_results.pop_front();
            compare_field("r_w", want.r_w, rsp_data.r_w);
            compare_field("r_i", want.r_i, rsp_data.r_i);
            compare_field("r_j", want.r_j, rsp_data.r_j);
            compare_field("r_k", want.r_k, rsp_data.r_k);
            compare_field("last_out", {31'b0, want.last_out}, {31'b0, rsp_data.last_out});
         end
      end
   end

   // watchdog: too many cycles in a row with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // reset registers: alpha = 1, left multiply, axpy, so r = x + y
   task automatic test_reset_state();
      send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      // x + y overflows both ways
      send_item(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
      send_item(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
      send_item(random_item());
   endtask

   // alpha = 2^-16 so every product is a pure shift: floor behavior on
   // both signs, scale only and then with y
   task automatic test_rounding();
      set_config(32'd1, 0, 0, 0, 1'b0, 1'b0);
      send_item(make_item(32'hFFFF_FFFF, 32'd1, -32'sd65537, 32'd65535,
                          $urandom, $urandom, $urandom, $urandom, 1'b1));
      set_config(32'd1, 0, 0, 0, 1'b0, 1'b1);
      send_item(make_item(32'hFFFF_FFFF, 32'd1, -32'sd65537, 32'd65535,
                          $urandom, $urandom, $urandom, $urandom, 1'b0));
   endtask

   // i * j = k but j * i = -k, so the side register must matter
   task automatic test_mul_side();
      set_config(0, Q_ONE, 0, 0, 1'b0, 1'b0);
      send_item(make_item(0, 0, Q_ONE, 0, 0, 0, 0, 0, 1'b0));
      send_item(random_item());
      set_config(0, Q_ONE, 0, 0, 1'b1, 1'b0);
      send_item(make_item(0, 0, Q_ONE, 0, 0, 0, 0, 0, 1'b1));
      send_item(random_item());
   endtask

   task automatic test_saturation();
      set_config(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0);
      send_item(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 1'b0));
      send_item(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0, 1'b1));
      set_config(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b1);
      send_item(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
      send_item(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
      // products just past the range pulled back by y: clamping before
      // the add would give a different answer
      set_config(Q_TWO, 0, 0, 0, 1'b0, 1'b1);
      send_item(make_item(32'h4000_0005, 32'hBFFF_FFFB, Q_MAX, Q_MIN,
                          -32'sd100, 32'sd100, Q_MIN, Q_MAX, 1'b1));
   endtask

   task automatic test_register_writes();
      // unmapped indexes leave every register alone
      wait_idle();
      write_reg(CSR_UNMAPPED_LO, $urandom);
      write_reg(CSR_UNMAPPED_HI, $urandom);
      send_item(random_item());
      // upper bits of the one-bit registers are dropped
      wait_idle();
      write_reg(CSR_MUL_SIDE, 32'hFFFF_FFFE);
      write_reg(CSR_OP_MODE, 32'h8000_0000);
      send_item(random_item());
      wait_idle();
      write_reg(CSR_MUL_SIDE, 32'h0000_0003);
      write_reg(CSR_OP_MODE, 32'hFFFF_FFFF);
      send_item(random_item());
   endtask

   // random vectors under a series of settings: the corner scale factors,
   // real and complex ones, and all four side / mode combinations
   task automatic test_random_streams();
      logic [31:0] a [4];
      for (int p = 0; p < PHASES; p++) begin
         for (int c = 0; c < 4; c++) a[c] = rand_component();
         case (p)
            0: a = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX};
            1: a = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN};
            2: begin
               a[1] = 0;
               a[2] = 0;
               a[3] = 0;
            end
            3: begin
               a[2] = 0;
               a[3] = 0;
            end
            default: ;
         endcase
         set_config(a[0], a[1], a[2], a[3], p[0], p[1]);
         // one phase streams with no gaps at all
         idling_on = (p != 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off mid-stream until the pipe is empty
            if (p == 7 && n == PHASE_ITEMS / 2) wait_idle();
            send_item(random_item());
         end
      end
      idling_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_rounding();
      test_mul_side();
      test_saturation();
      test_register_writes();
      test_random_streams();

      // drain, then give a stray late result time to show up
      wait_idle();
      repeat (LATENCY + 4) @(posedge clock);
      if (predicted_results.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", predicted_results.size()));

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/qaxs_pkg.sv
rtl/core/qaxs_lane.sv
rtl/core/quaternion_axpy_scale.sv
rtl/core/qaxs_check.sv
test/tb.sv
